[rtl/sorted_key_table_defines.svh]
// Assertion macros for the checker file of the sorted key table.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/skt_pkg.sv]
package skt_pkg;

    // Fixed widths of the request and response fields.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 64;
    localparam int EID_W    = 16;
    localparam int STATUS_W = 3;
    localparam int FID_W    = 16;
    localparam int CNT_O_W  = 7;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_ACT
    } t_state;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

[rtl/skt_if.sv]
// Request channel: one operation on the table.
interface skt_req_if;
    import skt_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [KEY_W-1:0]   key;
    logic [EID_W-1:0]   entry_id;

    modport source (output valid, mode, key, entry_id, input ready);
    modport sink   (input valid, mode, key, entry_id, output ready);
endinterface

// Response channel: the outcome of one operation.
interface skt_rsp_if;
    import skt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FID_W-1:0]    found_id;
    logic [CNT_O_W-1:0]  entry_count;

    modport source (output valid, status, found_id, entry_count, input ready);
    modport sink   (input valid, status, found_id, entry_count, output ready);
endinterface

[rtl/skt_cell.sv]
module skt_cell #(
    parameter int KEY_WIDTH = 64,
    parameter int ID_WIDTH  = 16
) (
    input  logic                 i_clk,
    input  skt_pkg::t_cell_ctrl  i_ctrl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [ID_WIDTH-1:0]  i_id,
    input  logic                 i_occ,
    input  logic [KEY_WIDTH-1:0] i_prev_key,
    input  logic [ID_WIDTH-1:0]  i_prev_id,
    input  logic                 i_prev_lt,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    input  logic [ID_WIDTH-1:0]  i_next_id,
    output logic [KEY_WIDTH-1:0] o_key,
    output logic [ID_WIDTH-1:0]  o_id,
    output logic                 o_lt,
    output logic                 o_eq,
    output logic                 o_idm
);
    import skt_pkg::*;

    logic [KEY_WIDTH-1:0] r_key;
    logic [ID_WIDTH-1:0]  r_id;
    logic                 r_lt;
    logic                 r_eq;
    logic                 r_idm;

    // Compare the broadcast key against the held entry; empty cells never match.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_lt  <= i_occ && (r_key < i_key);
            r_eq  <= i_occ && (r_key == i_key);
            r_idm <= (r_id == i_id);
        end
    end

    // Cells at or above the insert point shift up, and the first of them loads
    // the new entry. On a remove they take the entry of the cell above.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && !r_lt) begin
            if (i_prev_lt) begin
                r_key <= i_key;
                r_id  <= i_id;
            end else begin
                r_key <= i_prev_key;
                r_id  <= i_prev_id;
            end
        end else if (i_ctrl.del && !r_lt) begin
            r_key <= i_next_key;
            r_id  <= i_next_id;
        end
    end

    assign o_key = r_key;
    assign o_id  = r_id;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_idm = r_idm;
endmodule

[rtl/sorted_key_table.sv]
// Channel  | Port   | Direction | Payload
// ---------+--------+-----------+--------------------------------
// request  | i_req  | in        | mode, key, entry_id
// response | o_rsp  | out       | status, found_id, entry_count
//
// Every request passes a compare cycle, in which all cells compare the key in
// parallel, and an update cycle, in which the row shifts and the response is
// registered. A new request is taken in the update cycle, as the last one
// finishes, and not before; a stalled response holds the update cycle.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
module sorted_key_table #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 64,
    parameter int ID_WIDTH  = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state               r_state;
    t_state               n_state;
    t_cell_ctrl           w_ctrl;
    logic                 w_in_ready;
    logic                 w_finish;

    logic [MODE_W-1:0]    r_mode;
    logic [KEY_WIDTH-1:0] r_key;
    logic [ID_WIDTH-1:0]  r_id;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 r_rsp_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [FID_W-1:0]     r_found_id;
    logic [CNT_O_W-1:0]   r_entry_count;

    logic [KEY_WIDTH-1:0] w_key [CAPACITY];
    logic [ID_WIDTH-1:0]  w_id  [CAPACITY];
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    logic [CAPACITY-1:0]  w_idm;
    logic [CAPACITY-1:0]  w_occ;

    logic                 w_hit;
    logic                 w_id_ok;
    logic [ID_WIDTH-1:0]  w_sel_id;
    logic [STATUS_W-1:0]  w_status;
    logic [FID_W-1:0]     w_fid;
    logic                 w_do_ins;
    logic                 w_do_del;
    logic                 w_accept;

    assign w_accept = i_req.valid && w_in_ready;

    // Row of cells; each hands its entry to its neighbors when the row shifts.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_pk;
        logic [ID_WIDTH-1:0]  w_pi;
        logic                 w_plt;
        logic [KEY_WIDTH-1:0] w_nk;
        logic [ID_WIDTH-1:0]  w_ni;

        if (g == 0) begin : g_first
            assign w_pk  = r_key;
            assign w_pi  = r_id;
            assign w_plt = 1'b1;
        end else begin : g_mid
            assign w_pk  = w_key[g-1];
            assign w_pi  = w_id[g-1];
            assign w_plt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_nk = w_key[g];
            assign w_ni = w_id[g];
        end else begin : g_inner
            assign w_nk = w_key[g+1];
            assign w_ni = w_id[g+1];
        end

        assign w_occ[g] = (CNT_W'(g) < r_count);

        skt_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .ID_WIDTH  (ID_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_key      (r_key),
            .i_id       (r_id),
            .i_occ      (w_occ[g]),
            .i_prev_key (w_pk),
            .i_prev_id  (w_pi),
            .i_prev_lt  (w_plt),
            .i_next_key (w_nk),
            .i_next_id  (w_ni),
            .o_key      (w_key[g]),
            .o_id       (w_id[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g]),
            .o_idm      (w_idm[g])
        );
    end

    // Gather the match flags of the row; at most one cell matches.
    always_comb begin
        w_sel_id = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel_id = w_sel_id | (w_id[i] & {ID_WIDTH{w_eq[i]}});
        end
    end

    assign w_hit   = |w_eq;
    assign w_id_ok = |(w_eq & w_idm);

    // Decide the outcome of the held request from the registered compares.
    always_comb begin
        w_status = ST_OK;
        w_fid    = '0;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        n_count  = r_count;
        case (r_mode)
            MODE_ADD: begin
                if (w_hit) begin
                    w_status = ST_DUP;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (!w_hit) begin
                    w_status = ST_ABSENT;
                end else if (!w_id_ok) begin
                    w_status = ST_BADID;
                end else begin
                    w_do_del = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                if (w_hit) begin
                    w_fid = FID_W'(w_sel_id);
                end else begin
                    w_status = ST_ABSENT;
                end
            end
        endcase
    end

    // Sequencer: idle, compare cycle, then update cycle that waits for output room.
    always_comb begin
        n_state    = r_state;
        w_ctrl     = '0;
        w_in_ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctrl.cmp = 1'b1;
                n_state    = S_ACT;
            end
            S_ACT: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    w_finish   = 1'b1;
                    w_ctrl.ins = w_do_ins;
                    w_ctrl.del = w_do_del;
                    w_in_ready = 1'b1;
                    n_state    = i_req.valid ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Held request and response payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_req.mode;
            r_key  <= KEY_WIDTH'(i_req.key);
            r_id   <= ID_WIDTH'(i_req.entry_id);
        end
        if (w_finish) begin
            r_status      <= w_status;
            r_found_id    <= w_fid;
            r_entry_count <= CNT_O_W'(n_count);
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found_id    = r_found_id;
    assign o_rsp.entry_count = r_entry_count;
endmodule

[rtl/skt_checker.sv]
`include "sorted_key_table_defines.svh"

module skt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_ready,
    input  logic [skt_pkg::STATUS_W-1:0] i_rsp_status,
    input  logic [skt_pkg::FID_W-1:0]    i_rsp_found_id
);
    import skt_pkg::*;

    // A request that was just taken is still in its compare cycle.
    `SKT_ASSERT_NEXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready, "request taken during compare cycle")

    // Only the defined status codes appear.
    `SKT_ASSERT_NOW(a_status_range, i_rsp_valid, i_rsp_status <= ST_FULL, "undefined status code")

    // A nonzero id is only reported by a successful find.
    `SKT_ASSERT_NOW(a_fid_only_ok, i_rsp_valid && (i_rsp_found_id != '0), i_rsp_status == ST_OK, "id reported with failing status")

    // A stalled response keeps its content.
    `SKT_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_found_id), "stalled response changed")
endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_found_id (o_rsp.found_id)
);
